// ===== sv/dbo_pkg.sv =====
// Shared types, constants and helper functions for the detection box overlay.
// Used by every module of the block; depends on nothing.
package dbo_pkg;

  localparam int MAX_BOXES  = 8;
  localparam int COORD_BITS = 12;

  localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int CFG_W  = 13;
  localparam int DIM_W  = COORD_BITS + 1;
  localparam int POS_W  = COORD_BITS + 2;
  localparam int NORM_W = 16;
  localparam int PROD_W = NORM_W + DIM_W;
  localparam int LEN_W  = 5;
  localparam int SPAN_W = 7;

  localparam int LINE_W     = 2;
  localparam int CELL_W     = 6;
  localparam int CELL_H     = 10;
  localparam int LABEL_RISE = 10;

  // floor(d / 6) == (d * 171) >> 10 for d < 512
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;
  localparam int DIV6_W     = SPAN_W + 8;

  localparam int NAME_LEN_RED    = 6;
  localparam int NAME_LEN_GREEN  = 12;
  localparam int NAME_LEN_YELLOW = 7;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] COLOR_RED    = 2'd0;
  localparam logic [1:0] COLOR_GREEN  = 2'd1;
  localparam logic [1:0] COLOR_YELLOW = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [DIM_W-1:0] DIM_TOP = {1'b1, {COORD_BITS{1'b0}}};

  typedef enum logic [1:0] {
    HIT_NONE,
    HIT_EDGE,
    HIT_BLACK,
    HIT_WHITE
  } hit_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] box_left_norm;
    logic [15:0] box_top_norm;
    logic [15:0] box_width_norm;
    logic [15:0] box_height_norm;
    logic [7:0]  box_class;
    logic [6:0]  confidence_percent;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       overlay_hit;
  } out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } scaled_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [1:0]            color;
    logic [LEN_W-1:0]      label_len;
  } box_t;

  typedef struct packed {
    logic       clear;
    logic       append;
    scaled_t    scaled;
    logic [7:0] box_class;
    logic [6:0] confidence_percent;
  } tbl_req_t;

  // 0 acts as 1, anything above the coordinate range saturates
  function automatic logic [DIM_W-1:0] frame_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_TOP) begin
      r = DIM_TOP;
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [23:0] palette(input logic [1:0] color);
    logic [23:0] rgb;
    unique case (color)
      COLOR_RED:   rgb = 24'hFF0000;
      COLOR_GREEN: rgb = 24'h00FF00;
      default:     rgb = 24'hFFFF00;
    endcase
    return rgb;
  endfunction

endpackage

// ===== sv/dbo_box_table.sv =====
// Box table: clamps scaled append coordinates against the frame and stores boxes.
// Depends on dbo_pkg.
module dbo_box_table (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dbo_pkg::tbl_req_t                      req_i,
  input  logic [dbo_pkg::DIM_W-1:0]              fw_i,
  input  logic [dbo_pkg::DIM_W-1:0]              fh_i,
  output dbo_pkg::box_t [dbo_pkg::MAX_BOXES-1:0] boxes_o,
  output logic [dbo_pkg::CNT_W-1:0]              count_o
);

  dbo_pkg::box_t [dbo_pkg::MAX_BOXES-1:0] boxes_q;
  logic [dbo_pkg::CNT_W-1:0]              count_q;
  logic [dbo_pkg::CNT_W-1:0]              count_d;
  dbo_pkg::box_t                          new_box;
  logic                                   wr_en;

  always_comb begin
    logic [dbo_pkg::COORD_BITS-1:0] fw_m1;
    logic [dbo_pkg::COORD_BITS-1:0] fh_m1;
    logic [dbo_pkg::COORD_BITS-1:0] lim;
    logic [1:0]                     digits;
    logic [dbo_pkg::LEN_W-1:0]      base;
    fw_m1 = dbo_pkg::COORD_BITS'(fw_i - 1'b1);
    fh_m1 = dbo_pkg::COORD_BITS'(fh_i - 1'b1);

    new_box.x = (req_i.scaled.x > fw_m1) ? fw_m1 : req_i.scaled.x;
    new_box.y = (req_i.scaled.y > fh_m1) ? fh_m1 : req_i.scaled.y;
    lim       = fw_m1 - new_box.x;
    new_box.w = (req_i.scaled.w > lim) ? lim : req_i.scaled.w;
    lim       = fh_m1 - new_box.y;
    new_box.h = (req_i.scaled.h > lim) ? lim : req_i.scaled.h;

    priority if (req_i.confidence_percent < 7'd10) begin
      digits = 2'd1;
    end else if (req_i.confidence_percent < 7'd100) begin
      digits = 2'd2;
    end else begin
      digits = 2'd3;
    end

    priority if (req_i.box_class == 8'(dbo_pkg::COLOR_RED)) begin
      new_box.color = dbo_pkg::COLOR_RED;
      base          = dbo_pkg::LEN_W'(dbo_pkg::NAME_LEN_RED);
    end else if (req_i.box_class == 8'(dbo_pkg::COLOR_GREEN)) begin
      new_box.color = dbo_pkg::COLOR_GREEN;
      base          = dbo_pkg::LEN_W'(dbo_pkg::NAME_LEN_GREEN);
    end else begin
      new_box.color = dbo_pkg::COLOR_YELLOW;
      base          = dbo_pkg::LEN_W'(dbo_pkg::NAME_LEN_YELLOW);
    end
    // name, space, digits, percent sign
    new_box.label_len = base + dbo_pkg::LEN_W'(2) + dbo_pkg::LEN_W'(digits);
  end

  assign wr_en = req_i.append && (count_q < dbo_pkg::CNT_W'(dbo_pkg::MAX_BOXES));

  always_comb begin
    count_d = count_q;
    if (req_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      boxes_q[count_q[dbo_pkg::IDX_W-1:0]] <= new_box;
    end
  end

  assign boxes_o = boxes_q;
  assign count_o = count_q;

endmodule

// ===== sv/dbo_box_match.sv =====
// Per-box hit test of one pixel: edge bands and label strip cells.
// Depends on dbo_pkg.
module dbo_box_match (
  input  dbo_pkg::box_t                   box_i,
  input  logic [dbo_pkg::COORD_BITS-1:0]  col_i,
  input  logic [dbo_pkg::COORD_BITS-1:0]  row_i,
  input  logic [dbo_pkg::DIM_W-1:0]       fw_i,
  input  logic                            en_i,
  output dbo_pkg::hit_e                   kind_o
);

  localparam int PW = dbo_pkg::POS_W;

  always_comb begin
    logic [PW-1:0]                  x, y, col, row, cp, rp, xw, yh, ty, rrel, d;
    logic [dbo_pkg::COORD_BITS-1:0] ty_c;
    logic [dbo_pkg::SPAN_W-1:0]     span, dn, cpix;
    logic [dbo_pkg::DIV6_W-1:0]     qprod;
    logic [dbo_pkg::LEN_W-1:0]      c;
    logic [2:0]                     rem;
    logic                           hcols, vrows, edge_hit, lrows, lcols, fits, inner;

    x   = PW'(box_i.x);
    y   = PW'(box_i.y);
    col = PW'(col_i);
    row = PW'(row_i);
    cp  = col + PW'(dbo_pkg::LINE_W);
    rp  = row + PW'(dbo_pkg::LINE_W);
    xw  = x + PW'(box_i.w);
    yh  = y + PW'(box_i.h);

    // x - lw <= col  is checked as  col + lw >= x
    hcols = (cp >= x) && (col < xw + PW'(dbo_pkg::LINE_W));
    vrows = (rp >= y) && (row < yh + PW'(dbo_pkg::LINE_W));
    edge_hit = (hcols && (rp >= y)  && (row < y + PW'(dbo_pkg::LINE_W)))  ||
               (hcols && (rp >= yh) && (row < yh + PW'(dbo_pkg::LINE_W))) ||
               (vrows && (cp >= x)  && (col < x + PW'(dbo_pkg::LINE_W)))  ||
               (vrows && (cp >= xw) && (col < xw + PW'(dbo_pkg::LINE_W)));

    // label strip sits above the box, pinned to the top row
    ty_c = (box_i.y >= dbo_pkg::COORD_BITS'(dbo_pkg::LABEL_RISE)) ?
           box_i.y - dbo_pkg::COORD_BITS'(dbo_pkg::LABEL_RISE) : '0;
    ty    = PW'(ty_c);
    rrel  = row - ty;
    lrows = (row >= ty) && (rrel < PW'(dbo_pkg::CELL_H));

    span  = dbo_pkg::SPAN_W'(box_i.label_len) * dbo_pkg::SPAN_W'(dbo_pkg::CELL_W);
    d     = col - x;
    lcols = (col >= x) && (d < PW'(span));
    dn    = d[dbo_pkg::SPAN_W-1:0];
    qprod = dbo_pkg::DIV6_W'(dn) * dbo_pkg::DIV6_W'(dbo_pkg::DIV6_MUL);
    c     = qprod[dbo_pkg::DIV6_SHIFT +: dbo_pkg::LEN_W];
    cpix  = dbo_pkg::SPAN_W'(c) * dbo_pkg::SPAN_W'(dbo_pkg::CELL_W);
    rem   = 3'(dn - cpix);
    fits  = (x + PW'(cpix) + PW'(dbo_pkg::CELL_W)) < PW'(fw_i);
    inner = (rem != 3'd0) && (rem != 3'(dbo_pkg::CELL_W - 1)) &&
            (rrel != '0) && (rrel != PW'(dbo_pkg::CELL_H - 1));

    priority if (!en_i) begin
      kind_o = dbo_pkg::HIT_NONE;
    end else if (lrows && lcols && fits) begin
      kind_o = inner ? dbo_pkg::HIT_WHITE : dbo_pkg::HIT_BLACK;
    end else if (edge_hit) begin
      kind_o = dbo_pkg::HIT_EDGE;
    end else begin
      kind_o = dbo_pkg::HIT_NONE;
    end
  end

endmodule

// ===== sv/detection_box_overlay_core.sv =====
// Input register, scale register and result register lie between input transfer
// and result transfer. Throughput: one item per cycle while the output is not
// stalled; all stored boxes are tested in parallel and appends scale through four
// multipliers in one stage. Reset: box count cleared, frame size 640 x 480; box
// entries are not cleared. Clear, append and unused operations give no result.
module detection_box_overlay_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  dbo_pkg::in_t           in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dbo_pkg::out_t          out_data_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [dbo_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int CB = dbo_pkg::COORD_BITS;
  localparam int NB = dbo_pkg::MAX_BOXES;

  logic [dbo_pkg::DIM_W-1:0] fw_q, fh_q;

  logic            s1_valid_q, s2_valid_q, out_valid_q;
  dbo_pkg::in_t    s1_q, s2_q;
  dbo_pkg::scaled_t scl_d, s2_scl_q;
  dbo_pkg::out_t   out_q, out_d;

  logic out_ready, s2_is_pix, s2_go, s2_free, s1_go, s1_free, in_xfer;

  logic [dbo_pkg::PROD_W-1:0] prod_x, prod_y, prod_w, prod_h;

  dbo_pkg::tbl_req_t           tbl_req;
  dbo_pkg::box_t [NB-1:0]      boxes;
  logic [dbo_pkg::CNT_W-1:0]   box_count;
  dbo_pkg::hit_e               kind [NB];
  logic                        in_frame;
  logic [CB-1:0]               pix_col, pix_row;

  // frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= dbo_pkg::frame_dim(dbo_pkg::FRAME_WIDTH_RESET);
      fh_q <= dbo_pkg::frame_dim(dbo_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dbo_pkg::CFG_FRAME_WIDTH:  fw_q <= dbo_pkg::frame_dim(cfg_wdata_i);
        dbo_pkg::CFG_FRAME_HEIGHT: fh_q <= dbo_pkg::frame_dim(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_is_pix = (s2_q.operation == dbo_pkg::OP_PIXEL);
  assign s2_go     = s2_valid_q && (!s2_is_pix || out_ready);
  assign s2_free   = !s2_valid_q || s2_go;
  assign s1_go     = s1_valid_q && s2_free;
  assign s1_free   = !s1_valid_q || s1_go;
  assign in_stall_o = !s1_free;
  assign in_xfer   = in_valid_i && s1_free;

  // Q0.16 scaling by the frame size, truncated
  assign prod_x = dbo_pkg::PROD_W'(s1_q.box_left_norm)   * dbo_pkg::PROD_W'(fw_q);
  assign prod_y = dbo_pkg::PROD_W'(s1_q.box_top_norm)    * dbo_pkg::PROD_W'(fh_q);
  assign prod_w = dbo_pkg::PROD_W'(s1_q.box_width_norm)  * dbo_pkg::PROD_W'(fw_q);
  assign prod_h = dbo_pkg::PROD_W'(s1_q.box_height_norm) * dbo_pkg::PROD_W'(fh_q);

  always_comb begin
    scl_d.x = prod_x[dbo_pkg::NORM_W +: CB];
    scl_d.y = prod_y[dbo_pkg::NORM_W +: CB];
    scl_d.w = prod_w[dbo_pkg::NORM_W +: CB];
    scl_d.h = prod_h[dbo_pkg::NORM_W +: CB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_go;
      end
      if (out_ready) begin
        out_valid_q <= s2_go && s2_is_pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (s1_go) begin
      s2_q     <= s1_q;
      s2_scl_q <= scl_d;
    end
    if (out_ready && s2_go && s2_is_pix) begin
      out_q <= out_d;
    end
  end

  // table updates happen in stage 2, in order with pixel lookups
  always_comb begin
    tbl_req.clear              = s2_go && (s2_q.operation == dbo_pkg::OP_CLEAR);
    tbl_req.append             = s2_go && (s2_q.operation == dbo_pkg::OP_APPEND);
    tbl_req.scaled             = s2_scl_q;
    tbl_req.box_class          = s2_q.box_class;
    tbl_req.confidence_percent = s2_q.confidence_percent;
  end

  dbo_box_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .fw_i    (fw_q),
    .fh_i    (fh_q),
    .boxes_o (boxes),
    .count_o (box_count)
  );

  assign in_frame = (s2_q.pixel_column < fw_q) && (s2_q.pixel_row < fh_q);
  assign pix_col  = CB'(s2_q.pixel_column);
  assign pix_row  = CB'(s2_q.pixel_row);

  for (genvar k = 0; k < NB; k++) begin : g_match
    dbo_box_match u_match (
      .box_i  (boxes[k]),
      .col_i  (pix_col),
      .row_i  (pix_row),
      .fw_i   (fw_q),
      .en_i   (in_frame && (dbo_pkg::CNT_W'(k) < box_count)),
      .kind_o (kind[k])
    );
  end

  // last box in load order that hits wins
  always_comb begin
    logic [23:0] rgb;
    out_d.out_red     = s2_q.pixel_red;
    out_d.out_green   = s2_q.pixel_green;
    out_d.out_blue    = s2_q.pixel_blue;
    out_d.overlay_hit = 1'b0;
    for (int k = 0; k < NB; k++) begin
      unique case (kind[k])
        dbo_pkg::HIT_EDGE:  rgb = dbo_pkg::palette(boxes[k].color);
        dbo_pkg::HIT_BLACK: rgb = 24'h000000;
        dbo_pkg::HIT_WHITE: rgb = 24'hFFFFFF;
        default:            rgb = 24'h000000;
      endcase
      if (kind[k] != dbo_pkg::HIT_NONE) begin
        out_d.out_red     = rgb[23:16];
        out_d.out_green   = rgb[15:8];
        out_d.out_blue    = rgb[7:0];
        out_d.overlay_hit = 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.clear |=> (box_count == '0))
    else $error("box count not zero after clear");

  a_append_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_req.append && (box_count < dbo_pkg::CNT_W'(NB)))
    |=> (box_count == dbo_pkg::CNT_W'($past(box_count) + 1'b1)))
    else $error("append did not advance box count");

  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q && s2_is_pix))
    else $error("result produced without a pixel item");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
